// File: design/fractional_n_pll_word_calc_defines.svh
// ----------------------------------------------------------------------------
// fractional-n pll word calculator assertion macros
// shared property wrappers, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef FRACTIONAL_N_PLL_WORD_CALC_DEFINES_SVH
`define FRACTIONAL_N_PLL_WORD_CALC_DEFINES_SVH

// same-cycle implication
`define FNPLL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FNPLL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/fnpll_pkg.sv
// ----------------------------------------------------------------------------
// fnpll_pkg
// widths, constants and stage types of the divider word calculator
// ----------------------------------------------------------------------------
package fnpll_pkg;

	localparam int LO_W       = 33;
	localparam int VCO_W      = 37;
	localparam int REF_W      = 27;
	localparam int FREF_W     = 28;
	localparam int MOD_W      = 23;
	localparam int NUM_W      = FREF_W + MOD_W;
	localparam int INT_W      = 16;
	localparam int FRAC_W     = 24;
	localparam int DIV1_STEPS = VCO_W;
	localparam int DIV2_STEPS = MOD_W;

	localparam logic [MOD_W-1:0] FRAC_MODULUS    = 23'd8388593;
	localparam logic [REF_W-1:0] REF_CLOCK_RESET = 27'd40000000;

	typedef enum logic [1:0] {
		REF_X1   = 2'd0,
		REF_DIV2 = 2'd1,
		REF_DIV4 = 2'd2,
		REF_X2   = 2'd3
	} ref_code_t;

	typedef struct packed {
		logic [FREF_W-1:0] fref;
		logic [FRAC_W-1:0] offset;
		logic              fzero;
		logic              ovf;
		logic [INT_W-1:0]  iword;
	} side_t;

	// rem: partial remainder, num: dividend bits on top, quotient bits below
	typedef struct packed {
		logic [FREF_W-1:0] rem;
		logic [NUM_W-1:0]  num;
		side_t             side;
	} stage_t;

endpackage

// File: design/fractional_n_pll_word_calc.sv
// ----------------------------------------------------------------------------
// fractional_n_pll_word_calc
// integer and fractional divider words from an lo frequency request
// ----------------------------------------------------------------------------
// Takes one request per cycle and returns the results in order through an
// input register, a chain of 37 division cells for the integer
// quotient, one multiply stage, a chain of 23 division cells for the fraction,
// and the output register. A skid register behind the output keeps requests
// flowing while a result waits; req_ready drops only when that skid is full.
// ref_clock_hz takes effect for requests accepted after the write.
module fractional_n_pll_word_calc (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fnpll_pkg::REF_W-1:0]   cfg_wdata,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [fnpll_pkg::LO_W-1:0]    lo_freq_hz,
	input  logic [1:0]                    vco_div_code,
	input  logic [1:0]                    ref_div_code,
	input  logic [fnpll_pkg::FRAC_W-1:0]  frac_offset,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [fnpll_pkg::INT_W-1:0]   int_word,
	output logic [fnpll_pkg::FRAC_W-1:0]  frac_word,
	output logic                          int_overflow
);

	`include "fractional_n_pll_word_calc_defines.svh"

	typedef struct packed {
		logic [fnpll_pkg::INT_W-1:0]  iword;
		logic [fnpll_pkg::FRAC_W-1:0] fword;
		logic                         ovf;
	} result_t;

	logic [fnpll_pkg::REF_W-1:0]  ref_clock_q;
	logic [fnpll_pkg::FREF_W-1:0] fref;
	logic [fnpll_pkg::VCO_W-1:0]  vco;
	logic                         en;

	logic                         v1 [0:fnpll_pkg::DIV1_STEPS];
	fnpll_pkg::stage_t            d1 [0:fnpll_pkg::DIV1_STEPS];
	logic                         v2 [0:fnpll_pkg::DIV2_STEPS];
	fnpll_pkg::stage_t            d2 [0:fnpll_pkg::DIV2_STEPS];

	fnpll_pkg::stage_t            last;
	logic                         produced;
	result_t                      final_res;
	result_t                      rsp_q;
	logic                         rsp_v_q;
	result_t                      skid_q;
	logic                         skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_clock_q <= fnpll_pkg::REF_CLOCK_RESET;
		end else if (cfg_we) begin
			ref_clock_q <= cfg_wdata;
		end
	end

	always_comb begin
		unique case (fnpll_pkg::ref_code_t'(ref_div_code))
			fnpll_pkg::REF_X1:   fref = {1'b0, ref_clock_q};
			fnpll_pkg::REF_DIV2: fref = {2'b0, ref_clock_q[fnpll_pkg::REF_W-1:1]};
			fnpll_pkg::REF_DIV4: fref = {3'b0, ref_clock_q[fnpll_pkg::REF_W-1:2]};
			fnpll_pkg::REF_X2:   fref = {ref_clock_q, 1'b0};
			default:             fref = {1'b0, ref_clock_q};
		endcase
	end

	assign vco = fnpll_pkg::VCO_W'(lo_freq_hz) << ({1'b0, vco_div_code} + 3'd1);

	assign en        = !skid_v_q;
	assign req_ready = en;

	// input register feeds the quotient chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1[0] <= 1'b0;
		end else if (en) begin
			v1[0] <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d1[0].rem         <= '0;
			d1[0].num         <= {vco, {(fnpll_pkg::NUM_W - fnpll_pkg::VCO_W){1'b0}}};
			d1[0].side.fref   <= fref;
			d1[0].side.offset <= frac_offset;
			d1[0].side.fzero  <= (fref == '0);
			d1[0].side.ovf    <= 1'b0;
			d1[0].side.iword  <= '0;
		end
	end

	for (genvar i = 0; i < fnpll_pkg::DIV1_STEPS; i++) begin : g_quot
		fnpll_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (v1[i]),
			.in_data   (d1[i]),
			.out_valid (v1[i+1]),
			.out_data  (d1[i+1])
		);
	end

	fnpll_mul_stage u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v1[fnpll_pkg::DIV1_STEPS]),
		.in_data   (d1[fnpll_pkg::DIV1_STEPS]),
		.out_valid (v2[0]),
		.out_data  (d2[0])
	);

	for (genvar j = 0; j < fnpll_pkg::DIV2_STEPS; j++) begin : g_frac
		fnpll_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (v2[j]),
			.in_data   (d2[j]),
			.out_valid (v2[j+1]),
			.out_data  (d2[j+1])
		);
	end

	assign last     = d2[fnpll_pkg::DIV2_STEPS];
	assign produced = en && v2[fnpll_pkg::DIV2_STEPS];

	// zero reference: division result ignored, saturated integer word
	always_comb begin
		if (last.side.fzero) begin
			final_res.iword = '1;
			final_res.fword = last.side.offset;
			final_res.ovf   = 1'b1;
		end else begin
			final_res.iword = last.side.iword;
			final_res.fword = fnpll_pkg::FRAC_W'(last.num[fnpll_pkg::MOD_W-1:0])
				+ last.side.offset;
			final_res.ovf   = last.side.ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!rsp_v_q || rsp_ready) begin
			if (skid_v_q) begin
				rsp_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				rsp_v_q  <= produced;
			end
		end else if (produced) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!rsp_v_q || rsp_ready) begin
			rsp_q <= skid_v_q ? skid_q : final_res;
		end
		if (rsp_v_q && !rsp_ready && produced) begin
			skid_q <= final_res;
		end
	end

	assign rsp_valid    = rsp_v_q;
	assign int_word     = rsp_q.iword;
	assign frac_word    = rsp_q.fword;
	assign int_overflow = rsp_q.ovf;

	`FNPLL_ASSERT_NOW(a_skid_behind_rsp, skid_v_q, rsp_v_q,
		"skid holds a result while the output register is empty")
	`FNPLL_ASSERT_NOW(a_skid_fill_on_stall, $rose(skid_v_q),
		$past(rsp_v_q) && !$past(rsp_ready), "skid filled without an output stall")
	`FNPLL_ASSERT_NEXT(a_skid_drains, skid_v_q && rsp_ready, !skid_v_q,
		"skid did not drain when the output was taken")

endmodule

// File: design/fnpll_div_cell.sv
// ----------------------------------------------------------------------------
// fnpll_div_cell
// one restoring division step: brings in one dividend bit, emits one quotient bit
// ----------------------------------------------------------------------------
module fnpll_div_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  fnpll_pkg::stage_t   in_data,
	output logic                out_valid,
	output fnpll_pkg::stage_t   out_data
);

	logic [fnpll_pkg::FREF_W:0] trial;
	logic [fnpll_pkg::FREF_W:0] diff;
	logic                       ge;
	fnpll_pkg::stage_t          next_d;
	logic                       valid_q;
	fnpll_pkg::stage_t          data_q;

	assign trial = {in_data.rem, in_data.num[fnpll_pkg::NUM_W-1]};
	assign diff  = trial - {1'b0, in_data.side.fref};
	assign ge    = (trial >= {1'b0, in_data.side.fref});

	always_comb begin
		next_d      = in_data;
		next_d.rem  = ge ? diff[fnpll_pkg::FREF_W-1:0] : trial[fnpll_pkg::FREF_W-1:0];
		next_d.num  = {in_data.num[fnpll_pkg::NUM_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= next_d;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// File: design/fnpll_mul_stage.sv
// ----------------------------------------------------------------------------
// fnpll_mul_stage
// takes the integer quotient, scales the remainder by the fractional modulus
// ----------------------------------------------------------------------------
module fnpll_mul_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  fnpll_pkg::stage_t   in_data,
	output logic                out_valid,
	output fnpll_pkg::stage_t   out_data
);

	logic [fnpll_pkg::NUM_W-1:0] prod;
	fnpll_pkg::stage_t           next_d;
	logic                        valid_q;
	fnpll_pkg::stage_t           data_q;

	assign prod = fnpll_pkg::NUM_W'(in_data.rem) * fnpll_pkg::NUM_W'(fnpll_pkg::FRAC_MODULUS);

	// quotient of rem*M/fref is below M, so the top bits start as the remainder
	always_comb begin
		next_d            = in_data;
		next_d.rem        = prod[fnpll_pkg::NUM_W-1:fnpll_pkg::MOD_W];
		next_d.num        = {prod[fnpll_pkg::MOD_W-1:0],
			{(fnpll_pkg::NUM_W - fnpll_pkg::MOD_W){1'b0}}};
		next_d.side.ovf   = |in_data.num[fnpll_pkg::DIV1_STEPS-1:fnpll_pkg::INT_W];
		next_d.side.iword = in_data.num[fnpll_pkg::INT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= next_d;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// File: test/fnpll_word_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnpll_word_checker
// watches the request and response channels of the divider word calculator,
// predicts int_word, frac_word and int_overflow for every accepted request
// and compares them in order against the accepted responses
// ----------------------------------------------------------------------------
module fnpll_word_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fnpll_pkg::REF_W-1:0]      cfg_wdata,
	input  logic                             req_valid,
	input  logic                             req_ready,
	input  logic [fnpll_pkg::LO_W-1:0]       lo_freq_hz,
	input  logic [1:0]                       vco_div_code,
	input  logic [1:0]                       ref_div_code,
	input  logic [fnpll_pkg::FRAC_W-1:0]     frac_offset,
	input  logic                             rsp_valid,
	input  logic                             rsp_ready,
	input  logic [fnpll_pkg::INT_W-1:0]      int_word,
	input  logic [fnpll_pkg::FRAC_W-1:0]     frac_word,
	input  logic                             int_overflow,
	output int                               pending,
	output int                               fail_count
);

	typedef struct {
		logic [fnpll_pkg::INT_W-1:0]  iword;
		logic [fnpll_pkg::FRAC_W-1:0] fword;
		logic                         ovf;
	} divider_words_t;

	divider_words_t               words_due[$];
	logic [fnpll_pkg::REF_W-1:0]  ref_clock_hz;

	initial fail_count = 0;

	function automatic divider_words_t calc_divider_words(
		input logic [fnpll_pkg::REF_W-1:0]  refclk,
		input logic [fnpll_pkg::LO_W-1:0]   lo,
		input logic [1:0]                   vcode,
		input fnpll_pkg::ref_code_t         rcode,
		input logic [fnpll_pkg::FRAC_W-1:0] off
	);
		logic [63:0]    vco;
		logic [63:0]    fref;
		logic [63:0]    quot;
		logic [63:0]    rem;
		logic [63:0]    frac;
		divider_words_t w;
		vco = 64'(lo) << (int'(vcode) + 1);
		case (rcode)
			fnpll_pkg::REF_X1:   fref = 64'(refclk);
			fnpll_pkg::REF_DIV2: fref = 64'(refclk >> 1);
			fnpll_pkg::REF_DIV4: fref = 64'(refclk >> 2);
			default:             fref = 64'(refclk) << 1;
		endcase
		if (fref == 64'd0) begin
			// no division possible, saturate the integer word
			w.iword = '1;
			w.fword = off;
			w.ovf   = 1'b1;
		end else begin
			quot    = vco / fref;
			rem     = vco % fref;
			frac    = (rem * 64'(fnpll_pkg::FRAC_MODULUS)) / fref;
			w.iword = quot[fnpll_pkg::INT_W-1:0];
			w.fword = frac[fnpll_pkg::FRAC_W-1:0] + off;
			w.ovf   = (quot > 64'hFFFF);
		end
		return w;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ERROR %s: got %0d, expected %0d", $realtime, field, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		divider_words_t w;
		if (!arst_n) begin
			ref_clock_hz = fnpll_pkg::REF_CLOCK_RESET;
			words_due.delete();
			pending <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (words_due.size() == 0) begin
					report_mismatch("response with no request outstanding", 32'(int_word), 0);
				end else begin
					w = words_due.pop_front();
					if (int_word !== w.iword)
						report_mismatch("int_word", 32'(int_word), 32'(w.iword));
					if (frac_word !== w.fword)
						report_mismatch("frac_word", 32'(frac_word), 32'(w.fword));
					if (int_overflow !== w.ovf)
						report_mismatch("int_overflow", 32'(int_overflow), 32'(w.ovf));
				end
			end
			if (req_valid && req_ready)
				words_due.push_back(calc_divider_words(ref_clock_hz, lo_freq_hz,
					vco_div_code, fnpll_pkg::ref_code_t'(ref_div_code), frac_offset));
			// new reference applies to requests after this edge
			if (cfg_we)
				ref_clock_hz = cfg_wdata;
			pending <= words_due.size();
		end
	end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives tuning requests and reference clock settings into the divider word
// calculator under varied idle and backpressure patterns; the checker beside
// the block predicts and compares every response
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CLK_PERIOD      = 8;
	localparam int RESET_CYCLES    = 8;
	localparam int PHASES          = 12;
	localparam int ITEMS_PER_PHASE = 88;
	localparam int TAIL_CYCLES     = 80;
	localparam int CYCLE_LIMIT     = 500000;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         cfg_we;
	logic [fnpll_pkg::REF_W-1:0]  cfg_wdata;
	logic                         req_valid;
	logic                         req_ready;
	logic [fnpll_pkg::LO_W-1:0]   lo_freq_hz;
	logic [1:0]                   vco_div_code;
	logic [1:0]                   ref_div_code;
	logic [fnpll_pkg::FRAC_W-1:0] frac_offset;
	logic                         rsp_valid;
	logic                         rsp_ready;
	logic [fnpll_pkg::INT_W-1:0]  int_word;
	logic [fnpll_pkg::FRAC_W-1:0] frac_word;
	logic                         int_overflow;

	int                           pending;
	int                           fail_count;
	int                           gap_pct;
	int                           stall_pct;
	int                           cycle_count;
	logic [fnpll_pkg::REF_W-1:0]  ref_plan [PHASES];

	always #(CLK_PERIOD / 2) clk = ~clk;

	fractional_n_pll_word_calc uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.lo_freq_hz   (lo_freq_hz),
		.vco_div_code (vco_div_code),
		.ref_div_code (ref_div_code),
		.frac_offset  (frac_offset),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.int_word     (int_word),
		.frac_word    (frac_word),
		.int_overflow (int_overflow)
	);

	fnpll_word_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.lo_freq_hz   (lo_freq_hz),
		.vco_div_code (vco_div_code),
		.ref_div_code (ref_div_code),
		.frac_offset  (frac_offset),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.int_word     (int_word),
		.frac_word    (frac_word),
		.int_overflow (int_overflow),
		.pending      (pending),
		.fail_count   (fail_count)
	);

	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding", cycle_count, pending);
			$display("FAIL fractional_n_pll_word_calc");
			$finish;
		end
	end

	// valid stays high from one request to the next when there is no gap
	task automatic send_req(input logic [fnpll_pkg::LO_W-1:0] lo, input logic [1:0] vcode,
			input fnpll_pkg::ref_code_t rcode, input logic [fnpll_pkg::FRAC_W-1:0] off);
		while ($urandom_range(0, 99) < gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid    <= 1'b1;
		lo_freq_hz   <= lo;
		vco_div_code <= vcode;
		ref_div_code <= rcode;
		frac_offset  <= off;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_ref_clock(input logic [fnpll_pkg::REF_W-1:0] hz);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= hz;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [fnpll_pkg::LO_W-1:0] pick_lo();
		logic [fnpll_pkg::LO_W-1:0] lo;
		case ($urandom_range(0, 3))
			0: begin
				lo[fnpll_pkg::LO_W-1]   = 1'($urandom_range(0, 1));
				lo[fnpll_pkg::LO_W-2:0] = $urandom();
			end
			// typical rf tuning range
			1: lo = fnpll_pkg::LO_W'($urandom_range(32'd70000000, 32'd3000000000))
				+ fnpll_pkg::LO_W'($urandom_range(32'd0, 32'd3000000000));
			2: lo = fnpll_pkg::LO_W'($urandom_range(0, 1000));
			default: lo = '1 - fnpll_pkg::LO_W'($urandom_range(0, 1000));
		endcase
		return lo;
	endfunction

	function automatic logic [fnpll_pkg::FRAC_W-1:0] pick_offset();
		logic [fnpll_pkg::FRAC_W-1:0] off;
		case ($urandom_range(0, 3))
			0: off = '0;
			1: off = '1 - fnpll_pkg::FRAC_W'($urandom_range(0, 255));
			default: off = fnpll_pkg::FRAC_W'($urandom());
		endcase
		return off;
	endfunction

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		req_valid    = 1'b0;
		lo_freq_hz   = '0;
		vco_div_code = '0;
		ref_div_code = fnpll_pkg::REF_X1;
		frac_offset  = '0;
		rsp_ready    = 1'b0;
		gap_pct      = 0;
		stall_pct    = 0;
		cycle_count  = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed requests on the reset reference
		send_req('0, 2'd0, fnpll_pkg::REF_X1, '0);
		send_req('0, 2'd3, fnpll_pkg::REF_X2, '1);
		send_req('1, 2'd3, fnpll_pkg::REF_X1, '0);
		send_req('1, 2'd3, fnpll_pkg::REF_DIV4, '1);
		send_req(33'd200000000, 2'd0, fnpll_pkg::REF_X1, '0);
		// remainder two short of the reference, fraction wraps with the offset
		send_req(33'd219999999, 2'd0, fnpll_pkg::REF_X1, '1);
		for (int v = 0; v < 4; v++) begin
			for (int r = 0; r < 4; r++) begin
				send_req(33'd2450000123 + fnpll_pkg::LO_W'(v * 977 + r * 31), 2'(v),
					fnpll_pkg::ref_code_t'(r), pick_offset());
			end
		end

		// quotient straddling the 16-bit limit
		write_ref_clock(27'd1000000);
		send_req(33'd4096000000, 2'd3, fnpll_pkg::REF_X1, 24'd12345);
		send_req(33'd4095999999, 2'd3, fnpll_pkg::REF_X1, 24'd12345);

		ref_plan[0]  = 27'd4;
		ref_plan[1]  = '1;
		ref_plan[2]  = 27'd0;
		ref_plan[3]  = 27'd1;
		ref_plan[4]  = 27'd3;
		ref_plan[5]  = 27'd2;
		ref_plan[6]  = 27'd1000000;
		ref_plan[7]  = fnpll_pkg::REF_W'($urandom_range(4, 134217727));
		ref_plan[8]  = 27'd5;
		ref_plan[9]  = fnpll_pkg::REF_W'($urandom_range(4, 1000000));
		ref_plan[10] = fnpll_pkg::REF_W'($urandom_range(4, 134217727));
		ref_plan[11] = fnpll_pkg::REF_CLOCK_RESET;

		for (int p = 0; p < PHASES; p++) begin
			write_ref_clock(ref_plan[p]);
			case (p % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 84; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 84; end
				default: begin gap_pct = 13; stall_pct = 13; end
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// hold off mid-phase until the pipeline is empty
				if (i == ITEMS_PER_PHASE / 2)
					drain();
				send_req(pick_lo(), 2'($urandom_range(0, 3)),
					fnpll_pkg::ref_code_t'($urandom_range(0, 3)), pick_offset());
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS fractional_n_pll_word_calc");
		else
			$display("FAIL fractional_n_pll_word_calc");
		$finish;
	end

endmodule
